FILE: hw/rtl/mrlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrlc_pkg;

  // Number of line bytes kept for matching and digit capture.
  localparam int unsigned LINE_DEPTH = 256;
  localparam int unsigned POS_W = $clog2(LINE_DEPTH + 1);
  // Wide enough for topic_length plus the status digit offset.
  localparam int unsigned BASE_W = 10;
  localparam int unsigned PATTERN_COUNT = 6;
  localparam logic [PATTERN_COUNT-1:0] ALL_ALIVE = '1;

  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_PROMPT = 8'h3E;
  localparam logic [7:0] DIGIT_ZERO  = 8'h30;
  localparam logic [7:0] DIGIT_ONE   = 8'h31;

  // Configuration register indexes.
  localparam logic [7:0] CFG_BOX_ID       = 8'd0;
  localparam logic [7:0] CFG_TOPIC_LENGTH = 8'd1;
  localparam logic [7:0] CFG_MSG_TYPE     = 8'd2;
  localparam logic [7:0] CFG_MSG_LENGTH   = 8'd3;

  localparam logic [7:0] MSG_TYPE_RESET = 8'h30;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LINE   = 2'd1,
    MODE_SERVER = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    EV_PROMPT       = 4'd0,
    EV_PB_DONE      = 4'd1,
    EV_OK           = 4'd2,
    EV_ERROR        = 4'd3,
    EV_IP_CLOSE     = 4'd4,
    EV_RECV_FROM    = 4'd5,
    EV_SEND_OK      = 4'd6,
    EV_SERVER_START = 4'd7,
    EV_RELAY_CMD    = 4'd8
  } event_e;

  typedef struct packed {
    logic [7:0] box_id;
    logic [7:0] topic_length;
    logic [7:0] msg_type;
    logic [7:0] msg_length;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    event_e     kind;
    logic [7:0] relay_index;
    logic       relay_on;
  } event_t;

  // Known replies, padded with zeros to sixteen characters each.
  localparam logic [0:PATTERN_COUNT-1][0:15][7:0] REPLY_TEXT = {
    {"PB DONE", 8'h0D, 64'h0},
    {"OK", 8'h0D, 104'h0},
    {"ERROR", 8'h0D, 80'h0},
    {"+IPCLOSE", 64'h0},
    {"RECV FROM", 56'h0},
    {"Send ok", 8'h0D, 64'h0}
  };

  localparam logic [0:PATTERN_COUNT-1][3:0] REPLY_LEN = {
    4'd8, 4'd3, 4'd6, 4'd8, 4'd9, 4'd8
  };

endpackage

`default_nettype wire

FILE: hw/rtl/mrlc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module mrlc_cfg_regs (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_en_i,
  input  wire logic [7:0]     wr_index_i,
  input  wire logic [7:0]     wr_data_i,
  output mrlc_pkg::cfg_t      cfg_o
);

  mrlc_pkg::cfg_t cfg_q;
  mrlc_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        mrlc_pkg::CFG_BOX_ID:       cfg_d.box_id       = wr_data_i;
        mrlc_pkg::CFG_TOPIC_LENGTH: cfg_d.topic_length = wr_data_i;
        mrlc_pkg::CFG_MSG_TYPE:     cfg_d.msg_type     = wr_data_i;
        mrlc_pkg::CFG_MSG_LENGTH:   cfg_d.msg_length   = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_id       <= 8'h00;
      cfg_q.topic_length <= 8'h00;
      cfg_q.msg_type     <= mrlc_pkg::MSG_TYPE_RESET;
      cfg_q.msg_length   <= 8'h00;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mrlc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module mrlc_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic [7:0]     byte_i,
  input  wire mrlc_pkg::cfg_t cfg_i,
  output mrlc_pkg::event_t    evt_o
);

  localparam int unsigned POS_W = mrlc_pkg::POS_W;
  localparam int unsigned BASE_W = mrlc_pkg::BASE_W;
  localparam int unsigned PC = mrlc_pkg::PATTERN_COUNT;

  mrlc_pkg::mode_e mode_q, mode_d;
  logic [7:0]      prev_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [PC-1:0]   alive_q, alive_d;
  logic [7:0]      box_q, box_d;
  logic [7:0]      relay_q, relay_d;
  logic [7:0]      status_q, status_d;

  // Line state as seen by this byte: an idle parser starts from a clean line.
  logic             is_server;
  logic             is_idle;
  logic [POS_W-1:0] eff_pos;
  logic [PC-1:0]    eff_alive;
  logic [7:0]       eff_box, eff_relay, eff_status;

  logic line_end, header, is_prompt;

  // Result of storing the byte into the effective line.
  logic [POS_W-1:0] st_pos;
  logic [PC-1:0]    st_alive;
  logic [7:0]       st_box, st_relay, st_status;
  logic [BASE_W-1:0] base, pos_ext;

  logic                 class_hit;
  mrlc_pkg::event_e     class_kind;
  logic                 relay_hit;

  assign is_server = (mode_q == mrlc_pkg::MODE_SERVER);
  assign is_idle   = (mode_q != mrlc_pkg::MODE_SERVER) && (mode_q != mrlc_pkg::MODE_LINE);

  assign eff_pos    = is_idle ? '0 : pos_q;
  assign eff_alive  = is_idle ? mrlc_pkg::ALL_ALIVE : alive_q;
  assign eff_box    = is_idle ? 8'h00 : box_q;
  assign eff_relay  = is_idle ? 8'h00 : relay_q;
  assign eff_status = is_idle ? 8'h00 : status_q;

  assign line_end  = (prev_q == mrlc_pkg::CHAR_CR) && (byte_i == mrlc_pkg::CHAR_LF);
  assign header    = (prev_q == cfg_i.msg_type) && (byte_i == cfg_i.msg_length);
  assign is_prompt = (byte_i == mrlc_pkg::CHAR_PROMPT);

  assign base    = BASE_W'(cfg_i.topic_length) + BASE_W'(2);
  assign pos_ext = BASE_W'(eff_pos);

  always_comb begin
    st_pos    = eff_pos;
    st_alive  = eff_alive;
    st_box    = eff_box;
    st_relay  = eff_relay;
    st_status = eff_status;
    if (eff_pos < POS_W'(mrlc_pkg::LINE_DEPTH)) begin
      for (int k = 0; k < PC; k++) begin
        if (eff_pos < POS_W'(mrlc_pkg::REPLY_LEN[k]) &&
            byte_i != mrlc_pkg::REPLY_TEXT[k][eff_pos[3:0]]) begin
          st_alive[k] = 1'b0;
        end
      end
      priority if (pos_ext == base) begin
        st_box = byte_i;
      end else if (pos_ext == base + BASE_W'(1)) begin
        st_relay = byte_i;
      end else if (pos_ext == base + BASE_W'(2)) begin
        st_status = byte_i;
      end else begin
        // Not a digit position, nothing is captured.
      end
      st_pos = eff_pos + POS_W'(1);
    end
  end

  // First live reply, in list order, that the line is long enough to hold.
  always_comb begin
    class_hit  = 1'b0;
    class_kind = mrlc_pkg::EV_PB_DONE;
    for (int k = PC - 1; k >= 0; k--) begin
      if (eff_alive[k] && eff_pos >= POS_W'(mrlc_pkg::REPLY_LEN[k])) begin
        class_hit  = 1'b1;
        class_kind = mrlc_pkg::event_e'(4'(k + 1));
      end
    end
  end

  assign relay_hit = ({1'b0, eff_box} == ({1'b0, cfg_i.box_id} + {1'b0, mrlc_pkg::DIGIT_ZERO}));

  // Next state.
  always_comb begin
    mode_d   = mode_q;
    pos_d    = eff_pos;
    alive_d  = eff_alive;
    box_d    = eff_box;
    relay_d  = eff_relay;
    status_d = eff_status;
    if (is_server) begin
      priority if (line_end) begin
        mode_d = mrlc_pkg::MODE_IDLE;
      end else if (header) begin
        pos_d    = '0;
        alive_d  = mrlc_pkg::ALL_ALIVE;
        box_d    = 8'h00;
        relay_d  = 8'h00;
        status_d = 8'h00;
      end else begin
        pos_d    = st_pos;
        alive_d  = st_alive;
        box_d    = st_box;
        relay_d  = st_relay;
        status_d = st_status;
      end
    end else begin
      priority if (is_prompt || line_end) begin
        mode_d = mrlc_pkg::MODE_IDLE;
      end else if (header) begin
        mode_d   = mrlc_pkg::MODE_SERVER;
        pos_d    = '0;
        alive_d  = mrlc_pkg::ALL_ALIVE;
        box_d    = 8'h00;
        relay_d  = 8'h00;
        status_d = 8'h00;
      end else begin
        mode_d   = mrlc_pkg::MODE_LINE;
        pos_d    = st_pos;
        alive_d  = st_alive;
        box_d    = st_box;
        relay_d  = st_relay;
        status_d = st_status;
      end
    end
  end

  // Event for this byte.
  always_comb begin
    evt_o.valid       = 1'b0;
    evt_o.kind        = mrlc_pkg::EV_PROMPT;
    evt_o.relay_index = 8'h00;
    evt_o.relay_on    = 1'b0;
    if (is_server) begin
      if ((line_end || header) && relay_hit) begin
        evt_o.valid       = 1'b1;
        evt_o.kind        = mrlc_pkg::EV_RELAY_CMD;
        evt_o.relay_index = eff_relay - mrlc_pkg::DIGIT_ZERO;
        evt_o.relay_on    = (eff_status == mrlc_pkg::DIGIT_ONE);
      end
    end else begin
      priority if (is_prompt) begin
        evt_o.valid = 1'b1;
        evt_o.kind  = mrlc_pkg::EV_PROMPT;
      end else if (line_end) begin
        evt_o.valid = class_hit;
        evt_o.kind  = class_kind;
      end else if (header) begin
        evt_o.valid = 1'b1;
        evt_o.kind  = mrlc_pkg::EV_SERVER_START;
      end else begin
        // A stored byte gives no event.
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mrlc_pkg::MODE_IDLE;
      prev_q   <= 8'h00;
      pos_q    <= '0;
      alive_q  <= '0;
      box_q    <= 8'h00;
      relay_q  <= 8'h00;
      status_q <= 8'h00;
    end else if (step_i) begin
      mode_q   <= mode_d;
      prev_q   <= byte_i;
      pos_q    <= pos_d;
      alive_q  <= alive_d;
      box_q    <= box_d;
      relay_q  <= relay_d;
      status_q <= status_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/modem_response_line_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// rx        in         rx_valid_i / rx_ready_o  rx_byte_i
// ev        out        ev_valid_o / ev_ready_i  event_kind_o, relay_index_o, relay_on_o
// cfg       in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each accepted byte beat is registered in the byte stage and classified from there once
// the output register can advance; any event it produces is loaded into the output
// register as the byte leaves the byte stage, and the event beat is offered from there.
// One byte is taken every cycle unless stalled; the parser state updates once per byte.
// Reset clears the parser state and loads the register defaults.
// A stalled output register holds the byte stage, and rx_ready_o drops only while
// both the byte stage and the output register are full and the event is not taken.
// Configuration beats are always accepted and should be sent while the unit is idle.

module modem_response_line_classifier_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            ev_valid_o,
  input  wire logic       ev_ready_i,
  output logic [3:0]      event_kind_o,
  output logic [7:0]      relay_index_o,
  output logic            relay_on_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  mrlc_pkg::cfg_t   cfg;
  mrlc_pkg::event_t evt;

  // Byte stage.
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Output register.
  logic       out_valid_q;
  logic [3:0] out_kind_q;
  logic [7:0] out_index_q;
  logic       out_on_q;

  logic advance;
  logic step;

  // The output register can take a new value when it is empty or being drained.
  assign advance     = !out_valid_q || ev_ready_i;
  assign step        = in_valid_q && advance;
  assign rx_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  mrlc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  mrlc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .evt_o  (evt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_ready_o && rx_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && evt.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && evt.valid) begin
      out_kind_q  <= evt.kind;
      out_index_q <= evt.relay_index;
      out_on_q    <= evt.relay_on;
    end
  end

  assign ev_valid_o    = out_valid_q;
  assign event_kind_o  = out_kind_q;
  assign relay_index_o = out_index_q;
  assign relay_on_o    = out_on_q;

endmodule

`default_nettype wire
